// ----- hdl/spq_pkg.sv -----
// package for the severity priority queue
// types, constants and state encoding shared by all modules
package spq_pkg;

    localparam int CAPACITY_DEF = 64;

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_POP_EMPTY = 2'd1;
    localparam logic [1:0] ST_PUSH_FULL = 2'd2;

    typedef struct packed {
        logic [2:0]  severity;
        logic [15:0] exam_id;
        logic [15:0] subject_id;
        logic [15:0] machine_id;
        logic [31:0] time_stamp;
    } t_rec;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_INS,
        S_POP_FRONT,
        S_POP_MV,
        S_OUT
    } t_state;

    typedef struct packed {
        logic start_push;
        logic start_pop;
        logic take_front;
        logic scan_move;
        logic write_rec;
        logic pop_move;
        logic inc_count;
        logic dec_count;
        logic load_out;
        logic [1:0] status;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
        logic single;
        logic hit;
        logic idx_one;
        logic pop_last;
    } t_stat;

endpackage

// ----- hdl/spq_if.sv -----
// valid/ready channel interface carrying a payload type
// depends on nothing
interface spq_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- hdl/spq_in_t.sv -----
// input and output transaction payload types
// depends on spq_pkg
package spq_io_pkg;
    import spq_pkg::*;
    typedef struct packed {
        logic command;
        t_rec rec;
    } t_in;
    typedef struct packed {
        logic [1:0] status;
        t_rec       rec;
        logic [6:0] occupancy;
        logic       is_empty;
    } t_out;
endpackage

// ----- hdl/spq_ctrl.sv -----
// controller state machine for the priority queue
// depends on spq_pkg
module spq_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_command,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  spq_pkg::t_stat i_stat,
    output spq_pkg::t_cmd  o_cmd
);
    import spq_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_command == CMD_PUSH) begin
                        if (i_stat.full) begin
                            o_cmd.load_out = 1'b1;
                            o_cmd.status   = ST_PUSH_FULL;
                            n_state = S_OUT;
                        end else begin
                            o_cmd.start_push = 1'b1;
                            if (i_stat.empty) begin
                                n_state = S_INS;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                    end else begin
                        if (i_stat.empty) begin
                            o_cmd.load_out = 1'b1;
                            o_cmd.status   = ST_POP_EMPTY;
                            n_state = S_OUT;
                        end else begin
                            o_cmd.start_pop = 1'b1;
                            n_state = S_POP_FRONT;
                        end
                    end
                end
            end
            S_SCAN: begin
                if (i_stat.hit) begin
                    o_cmd.scan_move = 1'b1;
                    if (i_stat.idx_one) begin
                        n_state = S_INS;
                    end
                end else begin
                    o_cmd.write_rec = 1'b1;
                    o_cmd.inc_count = 1'b1;
                    o_cmd.load_out  = 1'b1;
                    o_cmd.status    = ST_OK;
                    n_state = S_OUT;
                end
            end
            S_INS: begin
                o_cmd.write_rec = 1'b1;
                o_cmd.inc_count = 1'b1;
                o_cmd.load_out  = 1'b1;
                o_cmd.status    = ST_OK;
                n_state = S_OUT;
            end
            S_POP_FRONT: begin
                o_cmd.take_front = 1'b1;
                if (i_stat.single) begin
                    o_cmd.dec_count = 1'b1;
                    o_cmd.load_out  = 1'b1;
                    o_cmd.status    = ST_OK;
                    n_state = S_OUT;
                end else begin
                    n_state = S_POP_MV;
                end
            end
            S_POP_MV: begin
                o_cmd.pop_move = 1'b1;
                if (i_stat.pop_last) begin
                    o_cmd.dec_count = 1'b1;
                    o_cmd.load_out  = 1'b1;
                    o_cmd.status    = ST_OK;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

// ----- hdl/spq_dp.sv -----
// datapath: record memory, walk index, count and output register
// depends on spq_pkg and spq_io_pkg
module spq_dp #(
    parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  spq_pkg::t_rec     i_rec,
    input  spq_pkg::t_cmd     i_cmd,
    output spq_pkg::t_stat    o_stat,
    output spq_io_pkg::t_out  o_out
);
    import spq_pkg::*;
    import spq_io_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    t_rec           r_mem [CAPACITY];
    logic [CW-1:0]  r_count;
    logic [CW-1:0]  r_idx;
    t_rec           r_in;
    t_rec           r_rd;
    t_rec           r_front;
    t_out           r_out;
    t_rec           w_front;
    t_rec           w_wr_data;
    logic           w_rd_en;
    logic           w_wr_en;
    logic [CW-1:0]  w_rd_addr;
    logic [CW-1:0]  w_wr_addr;
    logic [CW-1:0]  w_count_inc;
    logic [CW-1:0]  w_count_dec;

    assign w_count_inc = r_count + CW'(1);
    assign w_count_dec = r_count - CW'(1);
    assign w_front     = i_cmd.take_front ? r_rd : r_front;

    // push walks down from the tail, pop walks up from the front
    always_comb begin
        w_rd_en   = 1'b0;
        w_rd_addr = '0;
        if (i_cmd.start_push) begin
            w_rd_en   = (r_count != '0);
            w_rd_addr = w_count_dec;
        end else if (i_cmd.start_pop) begin
            w_rd_en   = 1'b1;
            w_rd_addr = '0;
        end else if (i_cmd.take_front) begin
            w_rd_en   = (r_count > CW'(1));
            w_rd_addr = CW'(1);
        end else if (i_cmd.scan_move) begin
            w_rd_en   = (r_idx > CW'(1));
            w_rd_addr = r_idx - CW'(2);
        end else if (i_cmd.pop_move) begin
            w_rd_en   = ((r_idx + CW'(1)) < r_count);
            w_rd_addr = r_idx + CW'(1);
        end
    end

    assign w_wr_en   = i_cmd.scan_move | i_cmd.write_rec | i_cmd.pop_move;
    assign w_wr_addr = i_cmd.pop_move ? (r_idx - CW'(1)) : r_idx;
    assign w_wr_data = i_cmd.write_rec ? r_in : r_rd;

    always_ff @(posedge i_clk) begin
        if (w_wr_en) r_mem[w_wr_addr[AW-1:0]] <= w_wr_data;
        if (w_rd_en) r_rd <= r_mem[w_rd_addr[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_idx   <= '0;
        end else begin
            if (i_cmd.inc_count) begin
                r_count <= w_count_inc;
            end else if (i_cmd.dec_count) begin
                r_count <= w_count_dec;
            end
            if (i_cmd.start_push) begin
                r_idx <= r_count;
            end else if (i_cmd.take_front) begin
                r_idx <= CW'(1);
            end else if (i_cmd.scan_move) begin
                r_idx <= r_idx - CW'(1);
            end else if (i_cmd.pop_move) begin
                r_idx <= r_idx + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start_push) r_in <= i_rec;
        if (i_cmd.take_front) r_front <= r_rd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out <= '0;
        end else if (i_cmd.load_out) begin
            r_out.status <= i_cmd.status;
            if (i_cmd.dec_count) begin
                r_out.rec       <= w_front;
                r_out.occupancy <= 7'(w_count_dec);
                r_out.is_empty  <= (w_count_dec == '0);
            end else if (i_cmd.inc_count) begin
                r_out.rec       <= '0;
                r_out.occupancy <= 7'(w_count_inc);
                r_out.is_empty  <= 1'b0;
            end else begin
                r_out.rec       <= '0;
                r_out.occupancy <= 7'(r_count);
                r_out.is_empty  <= (r_count == '0);
            end
        end
    end

    always_comb begin
        o_stat.full     = (r_count >= CW'(CAPACITY));
        o_stat.empty    = (r_count == '0);
        o_stat.single   = (r_count == CW'(1));
        o_stat.hit      = (r_rd.severity < r_in.severity);
        o_stat.idx_one  = (r_idx == CW'(1));
        o_stat.pop_last = ((r_idx + CW'(1)) >= r_count);
    end

    assign o_out = r_out;
endmodule

// ----- hdl/severity_priority_queue.sv -----
// severity priority queue: one push or pop command in, one result out
// push: lower-severity records move back one place, then the new record is written
// pop: the front record is returned, the rest move up; rejected: result next cycle
// one command at a time; the next is accepted only after the result is taken
// synchronous active-low reset empties the queue; record memory is not cleared
module severity_priority_queue #(
    parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    spq_if.sink   i_cmd,
    spq_if.source o_res
);
    import spq_pkg::*;
    import spq_io_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;
    t_in   w_in;
    t_out  w_out;

    assign w_in = i_cmd.data;
    assign o_res.data = w_out;

    spq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_cmd.valid),
        .i_command   (w_in.command),
        .o_in_ready  (i_cmd.ready),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    spq_dp #(.CAPACITY(CAPACITY)) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rec   (w_in.rec),
        .i_cmd   (w_cmd),
        .o_stat  (w_stat),
        .o_out   (w_out)
    );
endmodule

// ----- dv/spq_result_checker.sv -----
// result checker for the severity priority queue: watches both channels,
// keeps its own sorted record list and compares every result transaction
// depends on spq_pkg, spq_io_pkg and spq_if
`timescale 1ns / 100ps

module spq_result_checker #(
    parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    spq_if       i_cmd_mon,
    spq_if       i_res_mon,
    output int   o_fail_count,
    output int   o_pending
);
    import spq_pkg::*;
    import spq_io_pkg::*;

    t_rec held_recs[$];
    t_out expected_results[$];
    int   mismatch_count;
    int   pending;

    assign o_fail_count = mismatch_count;
    assign o_pending    = pending;

    function automatic t_out apply_command(input t_in cmd);
        t_out res;
        int   pos;
        res = '0;
        res.status = ST_OK;
        if (cmd.command == CMD_PUSH) begin
            if (held_recs.size() >= CAPACITY) begin
                res.status = ST_PUSH_FULL;
            end else begin
                pos = held_recs.size();
                for (int i = 0; i < held_recs.size(); i++) begin
                    if (held_recs[i].severity < cmd.rec.severity) begin
                        pos = i;
                        break;
                    end
                end
                held_recs.insert(pos, cmd.rec);
            end
        end else begin
            if (held_recs.size() == 0) begin
                res.status = ST_POP_EMPTY;
            end else begin
                res.rec = held_recs.pop_front();
            end
        end
        res.occupancy = 7'(held_recs.size());
        res.is_empty  = (held_recs.size() == 0);
        return res;
    endfunction

    function automatic void report_mismatch(input string what, input t_out exp_res,
                                            input t_out act_res);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch %0s: expected %h actual %h", what, exp_res, act_res);
    endfunction

    always @(posedge i_clk) begin
        t_out exp_res;
        t_out act_res;
        if (!i_rst_n) begin
            held_recs.delete();
            expected_results.delete();
            mismatch_count = 0;
            pending        = 0;
        end else begin
            if (i_res_mon.valid && i_res_mon.ready) begin
                act_res = i_res_mon.data;
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result", '0, act_res);
                end else begin
                    exp_res = expected_results.pop_front();
                    if (act_res.status !== exp_res.status)
                        report_mismatch("status", exp_res, act_res);
                    if (act_res.rec.severity !== exp_res.rec.severity)
                        report_mismatch("severity", exp_res, act_res);
                    if (act_res.rec.exam_id !== exp_res.rec.exam_id)
                        report_mismatch("exam_id", exp_res, act_res);
                    if (act_res.rec.subject_id !== exp_res.rec.subject_id)
                        report_mismatch("subject_id", exp_res, act_res);
                    if (act_res.rec.machine_id !== exp_res.rec.machine_id)
                        report_mismatch("machine_id", exp_res, act_res);
                    if (act_res.rec.time_stamp !== exp_res.rec.time_stamp)
                        report_mismatch("time_stamp", exp_res, act_res);
                    if (act_res.occupancy !== exp_res.occupancy)
                        report_mismatch("occupancy", exp_res, act_res);
                    if (act_res.is_empty !== exp_res.is_empty)
                        report_mismatch("is_empty", exp_res, act_res);
                end
            end
            if (i_cmd_mon.valid && i_cmd_mon.ready)
                expected_results.push_back(apply_command(i_cmd_mon.data));
            pending = expected_results.size();
        end
    end

endmodule

// ----- dv/testbench.sv -----
// top of the severity priority queue testbench: clock, reset, command
// stimulus, result stalls and verdict; depends on spq_pkg, spq_io_pkg,
// spq_if, spq_result_checker and severity_priority_queue
`timescale 1ns / 100ps

module testbench;
    import spq_pkg::*;
    import spq_io_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;

    logic i_clk;
    logic i_rst_n;
    int   cycle_count;
    int   fail_count;
    int   pending_count;

    spq_if #(.T(t_in))  cmd_if ();
    spq_if #(.T(t_out)) res_if ();

    severity_priority_queue uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if.sink),
        .o_res   (res_if.source)
    );

    spq_result_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_mon    (cmd_if),
        .i_res_mon    (res_if),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // receiver: changing stall pattern plus one long hold-off
    initial begin
        int mode;
        int hold_left;
        int rx_cycle;
        mode      = 0;
        hold_left = 0;
        rx_cycle  = 0;
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            rx_cycle++;
            if (rx_cycle % 300 == 0)
                mode = $urandom_range(0, 3);
            if (rx_cycle == 6000)
                hold_left = 800;
            if (hold_left > 0) begin
                hold_left--;
                res_if.ready = 1'b0;
            end else begin
                case (mode)
                    0: res_if.ready = 1'b1;
                    1: res_if.ready = ($urandom_range(0, 1) == 1);
                    2: res_if.ready = ($urandom_range(0, 4) == 0);
                    default: res_if.ready = ($urandom_range(0, 9) != 0);
                endcase
            end
        end
    end

    int burst_left;

    task automatic send_command(input t_in cmd);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            if ($urandom_range(0, 2) != 0) begin
                cmd_if.valid = 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge i_clk);
            end
        end
        burst_left--;
        cmd_if.valid = 1'b1;
        cmd_if.data  = cmd;
        do @(posedge i_clk); while (!cmd_if.ready);
        @(negedge i_clk);
        cmd_if.valid = 1'b0;
    endtask

    function automatic t_in make_push(input logic [2:0] sev, input logic [15:0] exam,
                                      input logic [15:0] subject, input logic [15:0] machine,
                                      input logic [31:0] stamp);
        t_in cmd;
        cmd.command        = CMD_PUSH;
        cmd.rec.severity   = sev;
        cmd.rec.exam_id    = exam;
        cmd.rec.subject_id = subject;
        cmd.rec.machine_id = machine;
        cmd.rec.time_stamp = stamp;
        return cmd;
    endfunction

    function automatic t_in random_command(input int push_pct);
        t_in  cmd;
        logic [2:0] sev;
        if ($urandom_range(0, 9) == 0)
            sev = 3'($urandom_range(0, 7));
        else
            sev = 3'($urandom_range(1, 6));
        cmd = make_push(sev, 16'($urandom), 16'($urandom), 16'($urandom), $urandom);
        if ($urandom_range(1, 100) > push_pct)
            cmd.command = CMD_POP;
        return cmd;
    endfunction

    initial begin
        t_in cmd;
        int  push_pct;
        cmd_if.valid = 1'b0;
        cmd_if.data  = '0;
        burst_left   = 0;
        i_rst_n      = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: empty pop, severity extremes, ties, field extremes
        cmd = '0;
        cmd.command = CMD_POP;
        send_command(cmd);
        send_command(make_push(3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF));
        send_command(make_push(3'd0, 16'h0000, 16'h0000, 16'h0000, 32'h0000_0000));
        send_command(make_push(3'd3, 16'h0001, 16'h0002, 16'h0003, 32'h0000_0004));
        send_command(make_push(3'd3, 16'h0011, 16'h0012, 16'h0013, 32'h0000_0014));
        send_command(make_push(3'd6, 16'hAAAA, 16'h5555, 16'hAAAA, 32'h5555_5555));
        send_command(make_push(3'd1, 16'h5555, 16'hAAAA, 16'h5555, 32'hAAAA_AAAA));
        send_command(make_push(3'd2, 16'h1234, 16'h5678, 16'h9ABC, 32'hDEAD_BEEF));
        send_command(make_push(3'd4, 16'h8000, 16'h8000, 16'h8000, 32'h8000_0000));
        send_command(make_push(3'd5, 16'h7FFF, 16'h7FFF, 16'h7FFF, 32'h7FFF_FFFF));
        send_command(make_push(3'd3, 16'h0021, 16'h0022, 16'h0023, 32'h0000_0024));
        cmd.command = CMD_POP;
        repeat (11) send_command(cmd);

        // random: phases biased toward filling (to reach full) or draining, or near balanced
        for (int n = 0; n < 1430; n++) begin
            if (n % 150 == 0) begin
                case ($urandom_range(0, 3))
                    0: push_pct = 92;
                    1: push_pct = 10;
                    2: push_pct = 60;
                    default: push_pct = 50;
                endcase
            end
            send_command(random_command(push_pct));
        end

        while (pending_count != 0) @(negedge i_clk);
        repeat (300) @(negedge i_clk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hdl/spq_pkg.sv
hdl/spq_if.sv
hdl/spq_in_t.sv
hdl/spq_ctrl.sv
hdl/spq_dp.sv
hdl/severity_priority_queue.sv
dv/spq_result_checker.sv
dv/testbench.sv
